/* src/wav_hdr_pkg.sv */
// types, tags and codes shared by the wav header parser
package wav_hdr_pkg;

  localparam int unsigned POS_BITS_DEF = 34;

  // four-character codes, first file byte in the top byte
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [5:0] MIN_FILE_LEN  = 6'd44;
  localparam logic [3:0] WALK_START    = 4'd12;
  localparam logic [4:0] FMT_CAP_LEN   = 5'd16;
  localparam int unsigned FMT_BITS_OFS = 14;
  localparam logic [15:0] FMT_PCM      = 16'd1;

  // chunk walk phases
  localparam logic [1:0] PH_HEADER    = 2'd0;
  localparam logic [1:0] PH_BODY_CHK  = 2'd1;
  localparam logic [1:0] PH_BODY_FREE = 2'd2;

  // result kinds
  localparam logic KIND_PCM    = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       final_byte;
  } wav_hdr_in_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  pcm_byte;
    logic        parse_ok;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [15:0] sample_bits;
    logic [15:0] block_align;
    logic [31:0] byte_rate;
    logic [31:0] payload_size;
    logic        run_end;
  } wav_hdr_out_t;

  // character idx of a four-character code
  function automatic logic [7:0] tag_char(input logic [31:0] tag, input logic [1:0] idx);
    logic [7:0] c;
    begin
      case (idx)
        2'd0:    c = tag[31:24];
        2'd1:    c = tag[23:16];
        2'd2:    c = tag[15:8];
        default: c = tag[7:0];
      endcase
      return c;
    end
  endfunction

endpackage

/* src/wav_header_chunk_parser_core.sv */
// wav header check, chunk walk, pcm word stream and final report
// every byte but the last is accepted back to back, one per cycle while the output is
// not stalled; a pcm word appears in the output register the cycle after its byte is accepted
// the last byte starts a report sequence on one shared 32x16 multiplier:
// two passes (block align, byte rate) and then the report load, which waits for a
// free output; no byte is taken meanwhile
// synchronous active-low reset clears control state; captured fmt bytes are not reset
module wav_header_chunk_parser_core #(
  parameter int unsigned POSITION_BITS = wav_hdr_pkg::POS_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  wav_hdr_pkg::wav_hdr_in_t  in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output wav_hdr_pkg::wav_hdr_out_t out_data
);
  import wav_hdr_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_MUL_A  = 2'd1;
  localparam logic [1:0] ST_MUL_B  = 2'd2;
  localparam logic [1:0] ST_REPORT = 2'd3;

  logic [1:0]               state_r, state_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [1:0]               phase_r, phase_nxt;
  logic [2:0]               idx_r, idx_nxt;
  logic [31:0]              tag_r, tag_nxt;
  logic [31:0]              len_r, len_nxt;
  logic [32:0]              remain_r, remain_nxt;
  logic                     magic_r, magic_nxt;
  logic                     fmt_found_r, fmt_found_nxt;
  logic                     data_found_r, data_found_nxt;
  logic                     in_pay_r, in_pay_nxt;
  logic [4:0]               cap_r, cap_nxt;
  logic [31:0]              pay_len_r, pay_len_nxt;
  logic                     ok_pre_r, ok_pre_nxt;
  logic [31:0]              prod_r, prod_nxt;
  logic [15:0]              ba_r, ba_nxt;
  logic                     out_valid_r, out_valid_nxt;
  wav_hdr_out_t             out_word_r, out_word_nxt;
  logic [7:0]               fmt_bytes_r [16];

  logic        accept;
  logic        out_free;
  logic        out_load;
  logic        fmt_wr;
  logic [7:0]  b;
  logic [32:0] remain_dec;
  logic        fail;
  logic [15:0] fmt_tag;
  logic [15:0] ch;
  logic [31:0] rate;
  logic [15:0] bits;
  logic        ok_fin;
  logic [31:0] mul_a;
  logic [15:0] mul_b;
  logic [47:0] mul_p;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == ST_IDLE) && out_free);
  assign accept    = in_valid && !in_stall;
  assign b         = in_data.file_byte;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  assign fmt_tag = {fmt_bytes_r[1], fmt_bytes_r[0]};
  assign ch      = {fmt_bytes_r[3], fmt_bytes_r[2]};
  assign rate    = {fmt_bytes_r[7], fmt_bytes_r[6], fmt_bytes_r[5], fmt_bytes_r[4]};
  assign bits    = {fmt_bytes_r[FMT_BITS_OFS+1], fmt_bytes_r[FMT_BITS_OFS]};
  assign ok_fin  = ok_pre_r && (fmt_tag == FMT_PCM) && (ch != '0) && (rate != '0)
                   && (bits != '0);

  // shared multiplier: channels*bits first, then rate*block align
  assign mul_a = (state_r == ST_MUL_A) ? {16'd0, ch} : rate;
  assign mul_b = (state_r == ST_MUL_A) ? bits : prod_r[18:3];
  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    phase_nxt      = phase_r;
    idx_nxt        = idx_r;
    tag_nxt        = tag_r;
    len_nxt        = len_r;
    remain_nxt     = remain_r;
    magic_nxt      = magic_r;
    fmt_found_nxt  = fmt_found_r;
    data_found_nxt = data_found_r;
    in_pay_nxt     = in_pay_r;
    cap_nxt        = cap_r;
    pay_len_nxt    = pay_len_r;
    ok_pre_nxt     = ok_pre_r;
    prod_nxt       = prod_r;
    ba_nxt         = ba_r;
    out_word_nxt   = out_word_r;
    out_load       = 1'b0;
    fmt_wr         = 1'b0;
    remain_dec     = remain_r;
    fail           = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (pos_r < POSITION_BITS'(4)) begin
            if (b != tag_char(TAG_RIFF, pos_r[1:0])) magic_nxt = 1'b0;
          end else if ((pos_r >= POSITION_BITS'(8)) && (pos_r < POSITION_BITS'(WALK_START))) begin
            if (b != tag_char(TAG_WAVE, pos_r[1:0])) magic_nxt = 1'b0;
          end

          if (cap_r < FMT_CAP_LEN) begin
            fmt_wr  = 1'b1;
            cap_nxt = cap_r + 5'd1;
          end

          if (pos_r >= POSITION_BITS'(WALK_START)) begin
            if (phase_r != PH_HEADER) begin
              if (in_pay_r) begin
                out_load               = 1'b1;
                out_word_nxt           = '0;
                out_word_nxt.item_kind = KIND_PCM;
                out_word_nxt.pcm_byte  = b;
                out_word_nxt.run_end   = !in_data.final_byte;
              end
              if (remain_r != '0) remain_dec = remain_r - 33'd1;
              remain_nxt = remain_dec;
              // pad byte is not payload
              if (remain_dec <= {32'd0, len_r[0]}) in_pay_nxt = 1'b0;
              if (remain_dec == '0) begin
                phase_nxt = PH_HEADER;
                idx_nxt   = '0;
              end
            end else begin
              if (!idx_r[2]) tag_nxt = {tag_r[23:0], b};
              else           len_nxt = {b, len_r[31:8]};
              idx_nxt = idx_r + 3'd1;
              if (idx_r == 3'd7) begin
                if ((tag_nxt == TAG_FMT) && !fmt_found_r) begin
                  fmt_found_nxt = 1'b1;
                  cap_nxt       = '0;
                end
                if ((tag_nxt == TAG_DATA) && !data_found_r) begin
                  data_found_nxt = 1'b1;
                  pay_len_nxt    = len_nxt;
                  in_pay_nxt     = (len_nxt != '0);
                end
                remain_nxt = {1'b0, len_nxt} + 33'(len_nxt[0]);
                if (remain_nxt == '0) phase_nxt = PH_HEADER;
                else if (!(fmt_found_r && data_found_r)) phase_nxt = PH_BODY_CHK;
                else phase_nxt = PH_BODY_FREE;
              end
            end
          end

          if (pos_r != '1) pos_nxt = pos_r + POSITION_BITS'(1);

          if (in_data.final_byte) begin
            fail = (phase_nxt == PH_BODY_CHK) && (remain_nxt > {32'd0, len_nxt[0]});
            ok_pre_nxt = (pos_nxt >= POSITION_BITS'(MIN_FILE_LEN)) && magic_nxt
                         && fmt_found_nxt && data_found_nxt && !fail
                         && (cap_nxt == FMT_CAP_LEN);
            state_nxt = ST_MUL_A;
          end
        end
      end
      ST_MUL_A: begin
        prod_nxt  = mul_p[31:0];
        state_nxt = ST_MUL_B;
      end
      ST_MUL_B: begin
        ba_nxt    = prod_r[18:3];
        prod_nxt  = mul_p[31:0];
        state_nxt = ST_REPORT;
      end
      ST_REPORT: begin
        if (out_free) begin
          out_load               = 1'b1;
          out_word_nxt           = '0;
          out_word_nxt.item_kind = KIND_REPORT;
          out_word_nxt.parse_ok  = ok_fin;
          out_word_nxt.run_end   = 1'b1;
          if (ok_fin) begin
            out_word_nxt.channel_count = ch;
            out_word_nxt.sample_rate   = rate;
            out_word_nxt.sample_bits   = bits;
            out_word_nxt.block_align   = ba_r;
            out_word_nxt.byte_rate     = prod_r;
            out_word_nxt.payload_size  = pay_len_r;
          end
          // back to the start of a new file
          pos_nxt        = '0;
          phase_nxt      = PH_HEADER;
          idx_nxt        = '0;
          tag_nxt        = '0;
          len_nxt        = '0;
          remain_nxt     = '0;
          magic_nxt      = 1'b1;
          fmt_found_nxt  = 1'b0;
          data_found_nxt = 1'b0;
          in_pay_nxt     = 1'b0;
          cap_nxt        = FMT_CAP_LEN;
          pay_len_nxt    = '0;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (out_load)        out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pos_r        <= '0;
      phase_r      <= PH_HEADER;
      idx_r        <= '0;
      tag_r        <= '0;
      len_r        <= '0;
      remain_r     <= '0;
      magic_r      <= 1'b1;
      fmt_found_r  <= 1'b0;
      data_found_r <= 1'b0;
      in_pay_r     <= 1'b0;
      cap_r        <= FMT_CAP_LEN;
      pay_len_r    <= '0;
      ok_pre_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pos_r        <= pos_nxt;
      phase_r      <= phase_nxt;
      idx_r        <= idx_nxt;
      tag_r        <= tag_nxt;
      len_r        <= len_nxt;
      remain_r     <= remain_nxt;
      magic_r      <= magic_nxt;
      fmt_found_r  <= fmt_found_nxt;
      data_found_r <= data_found_nxt;
      in_pay_r     <= in_pay_nxt;
      cap_r        <= cap_nxt;
      pay_len_r    <= pay_len_nxt;
      ok_pre_r     <= ok_pre_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    ba_r       <= ba_nxt;
    out_word_r <= out_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (fmt_wr) fmt_bytes_r[cap_r[3:0]] <= in_data.file_byte;
  end

endmodule

/* sim/wav_header_chunk_parser_core_tb.sv */
// testbench for the wav header parser: directed and random files checked against a tracking model
module wav_header_chunk_parser_core_tb;
  import wav_hdr_pkg::*;

  localparam logic [31:0] TAG_LIST = 32'h4C49_5354;
  localparam logic [31:0] TAG_JUNK = 32'h4A55_4E4B;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_BYTES = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  wav_hdr_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  wav_hdr_out_t out_data;

  bit in_idle_on = 1'b1;
  bit out_idle_on = 1'b1;
  int unsigned mismatches = 0;
  int unsigned files_sent = 0;
  int unsigned bytes_sent = 0;
  int unsigned pcm_words = 0;
  int unsigned reports = 0;
  int unsigned quiet_cycles = 0;

  logic [7:0] file_q[$];
  wav_hdr_out_t owed_words[$];

  // tracking copy of the parser state
  logic [33:0] pos_q;
  logic [1:0] phase_q;
  int unsigned hdr_idx;
  logic [31:0] tag_q;
  logic [31:0] len_q;
  logic [32:0] remain_q;
  bit magic_q;
  bit fmt_seen;
  bit data_seen;
  bit walk_bad;
  bit in_pcm;
  int unsigned cap_idx;
  logic [7:0] fmt_cap[16];
  logic [31:0] pcm_len;

  wav_header_chunk_parser_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= out_idle_on && ($urandom_range(99) < 15);
  end

  task automatic clear_tracker();
    pos_q = '0;
    phase_q = PH_HEADER;
    hdr_idx = 0;
    tag_q = '0;
    len_q = '0;
    remain_q = '0;
    magic_q = 1'b1;
    fmt_seen = 1'b0;
    data_seen = 1'b0;
    walk_bad = 1'b0;
    in_pcm = 1'b0;
    cap_idx = 32'(FMT_CAP_LEN);
    foreach (fmt_cap[i]) fmt_cap[i] = '0;
    pcm_len = '0;
  endtask

  task automatic track_walk(input logic [7:0] b, output bit pcm_hit);
    bit checked;
    pcm_hit = 1'b0;
    if (phase_q == PH_BODY_CHK || phase_q == PH_BODY_FREE) begin
      pcm_hit = in_pcm;
      if (remain_q != 0) remain_q = remain_q - 1'b1;
      if (remain_q <= len_q[0]) in_pcm = 1'b0;
      if (remain_q == 0) begin
        phase_q = PH_HEADER;
        hdr_idx = 0;
      end
      return;
    end
    if (hdr_idx < 4) tag_q = {tag_q[23:0], b};
    else len_q = {b, len_q[31:8]};
    hdr_idx++;
    if (hdr_idx < 8) return;
    hdr_idx = 0;
    // chunks are only checked until both fmt and data are known
    checked = !(fmt_seen && data_seen);
    if (tag_q == TAG_FMT && !fmt_seen) begin
      fmt_seen = 1'b1;
      cap_idx = 0;
    end
    if (tag_q == TAG_DATA && !data_seen) begin
      data_seen = 1'b1;
      pcm_len = len_q;
      in_pcm = (len_q != 0);
    end
    remain_q = {1'b0, len_q} + len_q[0];
    if (remain_q == 0) phase_q = PH_HEADER;
    else phase_q = checked ? PH_BODY_CHK : PH_BODY_FREE;
  endtask

  task automatic track_byte(input wav_hdr_in_t w);
    logic [33:0] at;
    int k;
    bit pcm_hit;
    bit ok;
    logic [15:0] f_tag;
    logic [15:0] f_ch;
    logic [15:0] f_bits;
    logic [15:0] f_ba;
    logic [31:0] f_rate;
    logic [31:0] prod;
    wav_hdr_out_t o;
    at = pos_q;
    k = int'(at[1:0]);
    if (at < 4) begin
      if (w.file_byte != TAG_RIFF[8*(3-k) +: 8]) magic_q = 1'b0;
    end else if (at >= 8 && at < WALK_START) begin
      if (w.file_byte != TAG_WAVE[8*(3-k) +: 8]) magic_q = 1'b0;
    end
    if (cap_idx < FMT_CAP_LEN) begin
      fmt_cap[cap_idx[3:0]] = w.file_byte;
      cap_idx++;
    end
    pcm_hit = 1'b0;
    if (at >= WALK_START) track_walk(w.file_byte, pcm_hit);
    if (pos_q != '1) pos_q = pos_q + 1'b1;
    if (pcm_hit) begin
      o = '0;
      o.item_kind = KIND_PCM;
      o.pcm_byte = w.file_byte;
      o.run_end = !w.final_byte;
      owed_words.push_back(o);
    end
    if (w.final_byte) begin
      if (phase_q == PH_BODY_CHK && remain_q > len_q[0]) walk_bad = 1'b1;
      o = '0;
      ok = pos_q >= MIN_FILE_LEN && magic_q && fmt_seen && data_seen && !walk_bad &&
           cap_idx == FMT_CAP_LEN;
      if (ok) begin
        f_tag = {fmt_cap[1], fmt_cap[0]};
        f_ch = {fmt_cap[3], fmt_cap[2]};
        f_rate = {fmt_cap[7], fmt_cap[6], fmt_cap[5], fmt_cap[4]};
        f_bits = {fmt_cap[FMT_BITS_OFS+1], fmt_cap[FMT_BITS_OFS]};
        if (f_tag != FMT_PCM || f_ch == 0 || f_rate == 0 || f_bits == 0) ok = 1'b0;
        if (ok) begin
          prod = 32'(f_ch) * 32'(f_bits);
          f_ba = prod[18:3];
          o.channel_count = f_ch;
          o.sample_rate = f_rate;
          o.sample_bits = f_bits;
          o.block_align = f_ba;
          o.byte_rate = f_rate * 32'(f_ba);
          o.payload_size = pcm_len;
        end
      end
      o.item_kind = KIND_REPORT;
      o.parse_ok = ok;
      o.run_end = 1'b1;
      owed_words.push_back(o);
      clear_tracker();
    end
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
  endtask

  task automatic compare_word(input wav_hdr_out_t got, input wav_hdr_out_t want);
    if (got.item_kind !== want.item_kind)
      note_mismatch("item_kind", 32'(got.item_kind), 32'(want.item_kind));
    if (got.pcm_byte !== want.pcm_byte)
      note_mismatch("pcm_byte", 32'(got.pcm_byte), 32'(want.pcm_byte));
    if (got.parse_ok !== want.parse_ok)
      note_mismatch("parse_ok", 32'(got.parse_ok), 32'(want.parse_ok));
    if (got.channel_count !== want.channel_count)
      note_mismatch("channel_count", 32'(got.channel_count), 32'(want.channel_count));
    if (got.sample_rate !== want.sample_rate)
      note_mismatch("sample_rate", got.sample_rate, want.sample_rate);
    if (got.sample_bits !== want.sample_bits)
      note_mismatch("sample_bits", 32'(got.sample_bits), 32'(want.sample_bits));
    if (got.block_align !== want.block_align)
      note_mismatch("block_align", 32'(got.block_align), 32'(want.block_align));
    if (got.byte_rate !== want.byte_rate)
      note_mismatch("byte_rate", got.byte_rate, want.byte_rate);
    if (got.payload_size !== want.payload_size)
      note_mismatch("payload_size", got.payload_size, want.payload_size);
    if (got.run_end !== want.run_end)
      note_mismatch("run_end", 32'(got.run_end), 32'(want.run_end));
  endtask

  always @(posedge clk) begin : word_check
    wav_hdr_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (owed_words.size() == 0) begin
        note_mismatch("word with nothing owed", {23'd0, out_data.pcm_byte, out_data.item_kind}, '0);
      end else begin
        want = owed_words.pop_front();
        compare_word(out_data, want);
        if (want.item_kind == KIND_REPORT) reports++;
        else pcm_words++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no word moved for %0d cycles, %0d still owed", quiet_cycles,
                 owed_words.size());
        $display("wav_header_chunk_parser_core_tb NOT OK");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input bit fin);
    wav_hdr_in_t w;
    w.file_byte = b;
    w.final_byte = fin;
    while (in_idle_on && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_byte(w);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
    files_sent++;
  endtask

  task automatic put_rand(input int unsigned n);
    repeat (n) file_q.push_back(8'($urandom_range(255)));
  endtask

  task automatic put_tag(input logic [31:0] tag);
    for (int i = 3; i >= 0; i--) file_q.push_back(tag[8*i +: 8]);
  endtask

  task automatic put_le(input logic [31:0] v, input int unsigned n);
    for (int i = 0; i < n; i++) file_q.push_back(v[8*i +: 8]);
  endtask

  task automatic start_riff();
    file_q.delete();
    put_tag(TAG_RIFF);
    put_le($urandom, 4);
    put_tag(TAG_WAVE);
  endtask

  task automatic put_chunk(input logic [31:0] tag, input logic [31:0] len,
                           input int unsigned body_n);
    put_tag(tag);
    put_le(len, 4);
    put_rand(body_n);
  endtask

  // fmt body of any length, the usual 16 bytes first and random bytes after
  task automatic add_fmt(input int unsigned len, input logic [15:0] ftag, input logic [15:0] ch,
                         input logic [31:0] rate, input logic [15:0] bits);
    logic [15:0] ba_junk;
    logic [31:0] rate_junk;
    logic [127:0] raw;
    ba_junk = 16'($urandom);
    rate_junk = $urandom;
    raw = {bits, ba_junk, rate_junk, rate, ch, ftag};
    put_tag(TAG_FMT);
    put_le(len, 4);
    for (int unsigned i = 0; i < len; i++) begin
      if (i < 16) file_q.push_back(raw[8*i +: 8]);
      else file_q.push_back(8'($urandom_range(255)));
    end
    if (len % 2) put_rand(1);
  endtask

  task automatic build_pcm(input logic [15:0] ftag, input logic [15:0] ch,
                           input logic [31:0] rate, input logic [15:0] bits,
                           input int unsigned dlen);
    start_riff();
    add_fmt(16, ftag, ch, rate, bits);
    put_chunk(TAG_DATA, dlen, dlen + dlen % 2);
  endtask

  task automatic test_plain_files();
    // exactly the minimum length
    build_pcm(FMT_PCM, 1, 8000, 8, 0);
    send_file();
    // odd data chunk with its pad byte missing at the end
    build_pcm(FMT_PCM, 2, 48000, 24, 3);
    void'(file_q.pop_back());
    send_file();
  endtask

  task automatic test_field_extremes();
    // block align and byte rate both wrap here
    build_pcm(FMT_PCM, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1);
    send_file();
  endtask

  task automatic test_format_rejects();
    build_pcm(16'd3, 2, 44100, 16, 2);
    send_file();
  endtask

  task automatic test_magic_and_length();
    build_pcm(FMT_PCM, 2, 44100, 16, 2);
    file_q[0] = file_q[0] ^ 8'h01;
    send_file();
    file_q.delete();
    put_rand(1);
    send_file();
    // one byte short of the minimum, data header unfinished
    build_pcm(FMT_PCM, 1, 8000, 8, 0);
    void'(file_q.pop_back());
    send_file();
  endtask

  task automatic test_chunk_walk();
    // later fmt and data chunks are ignored
    start_riff();
    add_fmt(16, FMT_PCM, 2, 44100, 16);
    put_chunk(TAG_DATA, 2, 2);
    add_fmt(16, 16'd3, 0, 0, 0);
    put_chunk(TAG_DATA, 3, 4);
    send_file();
    // data body runs past the end while still checked
    start_riff();
    add_fmt(16, FMT_PCM, 2, 44100, 16);
    put_chunk(TAG_DATA, 20, 5);
    send_file();
    // unchecked chunk cut short is fine
    start_riff();
    add_fmt(16, FMT_PCM, 2, 44100, 16);
    put_chunk(TAG_DATA, 2, 2);
    put_chunk(TAG_JUNK, 10, 2);
    send_file();
    // all-ones length while still checked
    start_riff();
    add_fmt(16, FMT_PCM, 2, 44100, 16);
    put_chunk(TAG_DATA, 32'hFFFF_FFFF, 6);
    send_file();
  endtask

  function automatic logic [15:0] pick_field16();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r < 3) return 16'($urandom);
    return 16'($urandom_range(1, 32));
  endfunction

  task automatic test_random_files();
    int unsigned first;
    int unsigned dlen;
    int unsigned flen;
    int unsigned cut;
    int unsigned n;
    int unsigned idx;
    logic [15:0] ftag;
    logic [31:0] rate;
    first = bytes_sent;
    while (bytes_sent - first < RANDOM_BYTES) begin
      if ($urandom_range(99) < 75) begin
        start_riff();
        if ($urandom_range(3) == 0) begin
          n = $urandom_range(5);
          put_chunk(TAG_LIST, n, n + n % 2);
        end
        case ($urandom_range(5))
          0: flen = 14;
          1: flen = 18;
          2: flen = $urandom_range(20);
          default: flen = 16;
        endcase
        ftag = ($urandom_range(7) == 0) ? 16'($urandom) : FMT_PCM;
        rate = ($urandom_range(9) == 0) ? 32'd0 : 32'($urandom);
        dlen = $urandom_range(12);
        if ($urandom_range(3) == 0) begin
          put_chunk(TAG_DATA, dlen, dlen + dlen % 2);
          add_fmt(flen, ftag, pick_field16(), rate, pick_field16());
        end else begin
          add_fmt(flen, ftag, pick_field16(), rate, pick_field16());
          put_chunk(TAG_DATA, dlen, dlen + dlen % 2);
        end
        if ($urandom_range(4) == 0) begin
          n = $urandom_range(4);
          put_chunk(TAG_JUNK, n, n + n % 2);
        end
        if ($urandom_range(4) == 0) begin
          cut = $urandom_range(1, file_q.size());
          while (file_q.size() > cut) void'(file_q.pop_back());
        end
        if ($urandom_range(5) == 0) begin
          idx = $urandom_range(file_q.size() - 1);
          file_q[idx] = file_q[idx] ^ (8'd1 << $urandom_range(7));
        end
      end else begin
        n = $urandom_range(1, 60);
        file_q.delete();
        if ($urandom_range(1)) start_riff();
        while (file_q.size() < n) put_rand(1);
      end
      send_file();
    end
  endtask

  initial begin
    clear_tracker();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_plain_files();
    test_field_extremes();
    test_format_rejects();
    test_magic_and_length();
    // no idling on either side through the chunk walk cases
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    test_chunk_walk();
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    test_random_files();
    in_valid <= 1'b0;
    while (owed_words.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    $display("sent %0d files in %0d bytes: directed header, format and chunk cases, then random",
             files_sent, bytes_sent);
    $display("checked %0d pcm words and %0d reports, %0d mismatches", pcm_words, reports,
             mismatches);
    if (mismatches == 0) begin
      $display("wav_header_chunk_parser_core_tb OK");
    end else begin
      $display("wav_header_chunk_parser_core_tb NOT OK");
    end
    $finish;
  end

endmodule
